### rtl/footprint_clearance_checker_defines.svh
// ---------------------------------------------------------------------------
// Footprint clearance checker assertion macros
// Shared assertion forms for the checker RTL.
// ---------------------------------------------------------------------------
`ifndef FOOTPRINT_CLEARANCE_CHECKER_DEFINES_SVH
`define FOOTPRINT_CLEARANCE_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FCC_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FCC_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/fcc_pkg.sv
// ---------------------------------------------------------------------------
// Footprint clearance checker package
// Shared types, register indexes and widths.
// ---------------------------------------------------------------------------
package fcc_pkg;

    localparam int unsigned MAX_DIM_DEF = 1024;

    localparam int unsigned COLS_W = 11;
    localparam int unsigned HALF_W = 9;
    localparam int unsigned TOL_W  = 21;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned DATA_W = 21;
    localparam int unsigned OCC_W  = 8;

    // Signed width that holds every strip bound and any cell position.
    localparam int unsigned BND_W  = 15;
    // Position width for the largest supported grid dimension.
    localparam int unsigned POS_W  = 12;

    localparam logic [IDX_W-1:0] REG_GRID_COLUMNS = 3'd0;
    localparam logic [IDX_W-1:0] REG_GRID_ROWS    = 3'd1;
    localparam logic [IDX_W-1:0] REG_HALF_LENGTH  = 3'd2;
    localparam logic [IDX_W-1:0] REG_HALF_WIDTH   = 3'd3;
    localparam logic [IDX_W-1:0] REG_MARGIN       = 3'd4;
    localparam logic [IDX_W-1:0] REG_TOLERANCE    = 3'd5;

    typedef struct packed {
        logic signed [BND_W-1:0] side_x_lo;
        logic signed [BND_W-1:0] side_x_hi;
        logic signed [BND_W-1:0] left_y_lo;
        logic signed [BND_W-1:0] left_y_hi;
        logic signed [BND_W-1:0] right_y_lo;
        logic signed [BND_W-1:0] right_y_hi;
        logic signed [BND_W-1:0] front_x_lo;
        logic signed [BND_W-1:0] front_x_hi;
        logic [TOL_W-1:0]        tolerance;
    } bounds_t;

    typedef struct packed {
        logic                    valid;
        logic signed [OCC_W-1:0] occupancy;
        logic                    last_cell;
        logic [POS_W-1:0]        x;
        logic [POS_W-1:0]        y;
    } cell_t;

endpackage

### rtl/fcc_geometry.sv
// ---------------------------------------------------------------------------
// Footprint clearance checker geometry
// Configuration registers, clamped grid size and registered strip bounds.
// ---------------------------------------------------------------------------
module fcc_geometry #(
    parameter int unsigned MAX_DIM = fcc_pkg::MAX_DIM_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fcc_pkg::IDX_W-1:0]     cfg_index,
    input  logic [fcc_pkg::DATA_W-1:0]    cfg_data,
    output logic [$clog2(MAX_DIM+1)-1:0]  grid_cols,
    output logic [$clog2(MAX_DIM+1)-1:0]  grid_rows,
    output fcc_pkg::bounds_t              bounds
);
    import fcc_pkg::*;

    localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
    localparam int unsigned CMP_W = (DIM_W > COLS_W) ? DIM_W : COLS_W;

    logic [COLS_W-1:0] cols_cfg_reg;
    logic [COLS_W-1:0] rows_cfg_reg;
    logic [HALF_W-1:0] half_len_reg;
    logic [HALF_W-1:0] half_wid_reg;
    logic [HALF_W-1:0] margin_reg;
    logic [TOL_W-1:0]  tol_reg;

    logic [DIM_W-1:0]  cols_clamped;
    logic [DIM_W-1:0]  rows_clamped;
    logic [CMP_W-1:0]  cols_ext;
    logic [CMP_W-1:0]  rows_ext;
    logic signed [BND_W-1:0] cx;
    logic signed [BND_W-1:0] cy;
    logic signed [BND_W-1:0] len_s;
    logic signed [BND_W-1:0] wid_s;
    logic signed [BND_W-1:0] mar_s;
    bounds_t           bounds_next;
    bounds_t           bounds_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_cfg_reg <= COLS_W'(1024);
            rows_cfg_reg <= COLS_W'(1024);
            half_len_reg <= HALF_W'(10);
            half_wid_reg <= HALF_W'(5);
            margin_reg   <= HALF_W'(10);
            tol_reg      <= TOL_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_GRID_COLUMNS: cols_cfg_reg <= cfg_data[COLS_W-1:0];
                REG_GRID_ROWS:    rows_cfg_reg <= cfg_data[COLS_W-1:0];
                REG_HALF_LENGTH:  half_len_reg <= cfg_data[HALF_W-1:0];
                REG_HALF_WIDTH:   half_wid_reg <= cfg_data[HALF_W-1:0];
                REG_MARGIN:       margin_reg   <= cfg_data[HALF_W-1:0];
                REG_TOLERANCE:    tol_reg      <= cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cols_ext = CMP_W'(cols_cfg_reg);
        rows_ext = CMP_W'(rows_cfg_reg);
        if (cols_ext == '0) begin
            cols_clamped = DIM_W'(1);
        end else if (cols_ext > CMP_W'(MAX_DIM)) begin
            cols_clamped = DIM_W'(MAX_DIM);
        end else begin
            cols_clamped = DIM_W'(cols_ext);
        end
        if (rows_ext == '0) begin
            rows_clamped = DIM_W'(1);
        end else if (rows_ext > CMP_W'(MAX_DIM)) begin
            rows_clamped = DIM_W'(MAX_DIM);
        end else begin
            rows_clamped = DIM_W'(rows_ext);
        end

        cx    = signed'(BND_W'(cols_clamped >> 1));
        cy    = signed'(BND_W'(rows_clamped >> 1));
        len_s = signed'(BND_W'(half_len_reg));
        wid_s = signed'(BND_W'(half_wid_reg));
        mar_s = signed'(BND_W'(margin_reg));

        bounds_next.side_x_lo  = cx - len_s - mar_s;
        bounds_next.side_x_hi  = cx + len_s + mar_s;
        bounds_next.left_y_lo  = cy + wid_s;
        bounds_next.left_y_hi  = cy + wid_s + mar_s;
        bounds_next.right_y_lo = cy - wid_s - mar_s;
        bounds_next.right_y_hi = cy - wid_s;
        bounds_next.front_x_lo = cx + len_s;
        bounds_next.front_x_hi = cx + len_s + mar_s;
        bounds_next.tolerance  = tol_reg;
    end

    always_ff @(posedge aclk) begin
        bounds_reg <= bounds_next;
    end

    // The position tracker sees a new grid size in the cycle after the write.
    assign bounds    = bounds_reg;
    assign grid_cols = cols_clamped;
    assign grid_rows = rows_clamped;

endmodule

### rtl/fcc_cell_stage.sv
// ---------------------------------------------------------------------------
// Footprint clearance checker cell stage
// Input register and the column and row position tracker.
// ---------------------------------------------------------------------------
module fcc_cell_stage #(
    parameter int unsigned MAX_DIM = fcc_pkg::MAX_DIM_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fcc_pkg::OCC_W-1:0]     s_occupancy,
    input  logic                          s_last_cell,
    input  logic [$clog2(MAX_DIM+1)-1:0]  grid_cols,
    input  logic [$clog2(MAX_DIM+1)-1:0]  grid_rows,
    input  logic                          advance,
    output fcc_pkg::cell_t                grid_item
);
    import fcc_pkg::*;

    localparam int unsigned PW    = $clog2(MAX_DIM);

    logic [PW-1:0] x_reg;
    logic [PW-1:0] y_reg;
    logic [PW-1:0] x_next;
    logic [PW-1:0] y_next;
    logic [PW:0]   x_plus;
    logic [PW:0]   y_plus;
    logic          accept;
    logic          valid_reg;
    cell_t         cell_reg;

    assign s_tready = !valid_reg || advance;
    assign accept   = s_tvalid && s_tready;
    assign x_plus   = {1'b0, x_reg} + (PW+1)'(1);
    assign y_plus   = {1'b0, y_reg} + (PW+1)'(1);

    always_comb begin
        x_next = x_reg;
        y_next = y_reg;
        if (s_last_cell) begin
            x_next = '0;
            y_next = '0;
        end else if (x_plus >= (PW+1)'(grid_cols)) begin
            x_next = '0;
            y_next = (y_plus >= (PW+1)'(grid_rows)) ? '0 : y_plus[PW-1:0];
        end else begin
            x_next = x_plus[PW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg     <= '0;
            y_reg     <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                x_reg     <= x_next;
                y_reg     <= y_next;
                valid_reg <= 1'b1;
            end else if (advance) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cell_reg.valid     <= 1'b1;
            cell_reg.occupancy <= signed'(s_occupancy);
            cell_reg.last_cell <= s_last_cell;
            cell_reg.x         <= POS_W'(x_reg);
            cell_reg.y         <= POS_W'(y_reg);
        end
    end

    always_comb begin
        grid_item       = cell_reg;
        grid_item.valid = valid_reg;
    end

endmodule

### rtl/fcc_region_count.sv
// ---------------------------------------------------------------------------
// Footprint clearance checker region counters
// Strip membership, saturating counts and the result register.
// ---------------------------------------------------------------------------
`include "footprint_clearance_checker_defines.svh"

module fcc_region_count (
    input  logic             aclk,
    input  logic             aresetn,
    input  fcc_pkg::cell_t   grid_item,
    input  fcc_pkg::bounds_t bounds,
    output logic             advance,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [2:0]       m_flags
);
    import fcc_pkg::*;

    logic signed [BND_W-1:0] xs;
    logic signed [BND_W-1:0] ys;
    logic             occupied;
    logic             side_x;
    logic             left_hit;
    logic             right_hit;
    logic             front_hit;
    logic [TOL_W-1:0] left_count_reg;
    logic [TOL_W-1:0] right_count_reg;
    logic [TOL_W-1:0] front_count_reg;
    logic [TOL_W-1:0] left_count_next;
    logic [TOL_W-1:0] right_count_next;
    logic [TOL_W-1:0] front_count_next;
    logic             fire;
    logic             valid_reg;
    logic [2:0]       flags_reg;

    assign advance = !(grid_item.last_cell && valid_reg && !m_tready);
    assign fire    = grid_item.valid && advance;

    always_comb begin
        xs        = signed'(BND_W'(grid_item.x));
        ys        = signed'(BND_W'(grid_item.y));
        occupied  = grid_item.occupancy > 0;
        side_x    = xs >= bounds.side_x_lo && xs <= bounds.side_x_hi;
        left_hit  = occupied && side_x
                    && ys >= bounds.left_y_lo && ys <= bounds.left_y_hi;
        right_hit = occupied && side_x
                    && ys >= bounds.right_y_lo && ys <= bounds.right_y_hi;
        front_hit = occupied
                    && xs >= bounds.front_x_lo && xs <= bounds.front_x_hi
                    && ys >= bounds.right_y_lo && ys <= bounds.left_y_hi;

        left_count_next  = left_count_reg;
        right_count_next = right_count_reg;
        front_count_next = front_count_reg;
        if (left_hit && left_count_reg < bounds.tolerance) begin
            left_count_next = left_count_reg + TOL_W'(1);
        end
        if (right_hit && right_count_reg < bounds.tolerance) begin
            right_count_next = right_count_reg + TOL_W'(1);
        end
        if (front_hit && front_count_reg < bounds.tolerance) begin
            front_count_next = front_count_reg + TOL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_count_reg  <= '0;
            right_count_reg <= '0;
            front_count_reg <= '0;
            valid_reg       <= 1'b0;
        end else begin
            if (valid_reg && m_tready) begin
                valid_reg <= 1'b0;
            end
            if (fire) begin
                if (grid_item.last_cell) begin
                    left_count_reg  <= '0;
                    right_count_reg <= '0;
                    front_count_reg <= '0;
                    valid_reg       <= 1'b1;
                end else begin
                    left_count_reg  <= left_count_next;
                    right_count_reg <= right_count_next;
                    front_count_reg <= front_count_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && grid_item.last_cell) begin
            flags_reg[0] <= left_count_next < bounds.tolerance;
            flags_reg[1] <= right_count_next < bounds.tolerance;
            flags_reg[2] <= front_count_next < bounds.tolerance;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_flags  = flags_reg;

    `FCC_ASSERT_NEXT(a_result_after_last, aclk, aresetn,
        fire && grid_item.last_cell, valid_reg, "Last cell did not produce a result.")
    `FCC_ASSERT_NEXT(a_counts_cleared, aclk, aresetn,
        fire && grid_item.last_cell,
        left_count_reg == '0 && right_count_reg == '0 && front_count_reg == '0,
        "Counters not cleared after the last cell.")
    `FCC_ASSERT_NEXT(a_zero_tol_blocked, aclk, aresetn,
        fire && grid_item.last_cell && bounds.tolerance == '0, flags_reg == 3'b000,
        "Zero tolerance reported a clear strip.")

endmodule

### rtl/footprint_clearance_checker.sv
// ---------------------------------------------------------------------------
// Footprint clearance checker
// Counts occupied grid cells in three strips around the robot footprint.
// ---------------------------------------------------------------------------
// Cells stream in on the s_ channel in row-major order, one per transfer,
// with s_tlast on the final cell of a frame. The block tracks column and
// row itself. On the final cell one transfer leaves on the m_ channel with
// the left, right and front clear flags; other cells produce no transfer.
// A cell is accepted in every cycle while the result register is free or
// being drained, so throughput is one cell per clock.
// The final cell is held in the input register until the result register can
// take it; its flags are then loaded into the result register, which raises
// m_tvalid.
// The cfg_ channel writes a register by index; cfg_ready is always high.
// Writes are to be made only while no frame is in flight; the block has no check for it.
// Reset restores the default configuration and clears the position and
// counters. When the receiver stalls on a pending result, a following
// final cell waits in the input register and s_tready drops; ordinary
// cells keep flowing.
// ---------------------------------------------------------------------------
module footprint_clearance_checker #(
    parameter int unsigned MAX_DIM = fcc_pkg::MAX_DIM_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] occupancy
    input  logic                       s_tlast,   // last_cell
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,   // [0] left free, [1] right free,
                                                  // [2] front free, [7:3] zero
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [fcc_pkg::IDX_W-1:0]  cfg_index,
    input  logic [fcc_pkg::DATA_W-1:0] cfg_data
);
    import fcc_pkg::*;

    localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);

    logic [DIM_W-1:0] grid_cols;
    logic [DIM_W-1:0] grid_rows;
    bounds_t          bounds;
    cell_t            grid_item;
    logic             advance;
    logic [2:0]       flags;

    fcc_geometry #(
        .MAX_DIM (MAX_DIM)
    ) u_geometry (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .grid_cols (grid_cols),
        .grid_rows (grid_rows),
        .bounds    (bounds)
    );

    fcc_cell_stage #(
        .MAX_DIM (MAX_DIM)
    ) u_cell_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_occupancy (s_tdata[OCC_W-1:0]),
        .s_last_cell (s_tlast),
        .grid_cols   (grid_cols),
        .grid_rows   (grid_rows),
        .advance     (advance),
        .grid_item   (grid_item)
    );

    fcc_region_count u_region_count (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .grid_item (grid_item),
        .bounds    (bounds),
        .advance   (advance),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_flags   (flags)
    );

    assign m_tdata = {5'b00000, flags};

endmodule
